[design/enu_pose_to_ned_euler_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the pose conversion core
// Immediate-consequence and next-cycle implication checks on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef ENU_POSE_TO_NED_EULER_CORE_DEFINES_SVH
`define ENU_POSE_TO_NED_EULER_CORE_DEFINES_SVH

// same-cycle implication
`define EPN_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EPN_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/epn_pkg.sv]
// ----------------------------------------------------------------------------
// epn_pkg
// Types and constants shared by the pose conversion pipeline.
// ----------------------------------------------------------------------------
package epn_pkg;

  localparam int XW       = 38;  // CORDIC x/y width
  localparam int ZW       = 34;  // CORDIC angle accumulator, 2^-30 rad
  localparam int OW       = 34;  // quaternion product sums, Q.30
  localparam int SQW      = 62;  // square root remainder / root
  localparam int SQ_STEPS = 31;  // one root bit per stage
  localparam int MAX_ITER = 24;

  localparam logic signed [16:0] PI_Q13      = 17'sd25736;
  localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
  localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629712;
  localparam logic signed [OW-1:0] ONE_Q30     = 34'sd1073741824;

  localparam logic [31:0] ATAN_TAB [0:MAX_ITER-1] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef struct packed {
    logic [31:0] north;
    logic [31:0] east;
    logic [31:0] down;
    logic [15:0] vn;
    logic [15:0] ve;
    logic [15:0] vd;
    logic        clamped;
  } side_t;

  typedef struct packed {
    logic signed [31:0] xw;
    logic signed [31:0] zy;
    logic signed [31:0] xx;
    logic signed [31:0] yy;
    logic signed [31:0] wy;
    logic signed [31:0] xz;
    logic signed [31:0] zw;
    logic signed [31:0] xy;
    logic signed [31:0] zz;
  } prod_t;

  typedef struct packed {
    logic signed [OW-1:0] px;
    logic signed [OW-1:0] pxx;
    logic signed [OW-1:0] hy;
    logic signed [OW-1:0] hx;
    logic signed [31:0]   s;
  } op_t;

  typedef struct packed {
    logic [SQW-1:0] rem;
    logic [SQW-1:0] res;
  } sq_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } lane_t;

  typedef struct packed {
    lane_t pitch;
    lane_t roll;
    lane_t head;
  } lane3_t;

  typedef struct packed {
    logic [31:0] ned_north;
    logic [31:0] ned_east;
    logic [31:0] ned_down;
    logic [14:0] roll;
    logic [15:0] pitch;
    logic [15:0] heading;
    logic [15:0] vel_north;
    logic [15:0] vel_east;
    logic [15:0] vel_down;
    logic        clamped;
  } res_t;

  function automatic logic [31:0] neg_sat32(input logic [31:0] v);
    if (v == 32'h8000_0000) return 32'h7FFF_FFFF;
    return 32'(-v);
  endfunction

  function automatic logic [15:0] neg_sat16(input logic [15:0] v);
    if (v == 16'h8000) return 16'h7FFF;
    return 16'(-v);
  endfunction

endpackage

[design/enu_pose_to_ned_euler_core.sv]
// Throughput: one item per cycle, stalled while the output queue is full; set by the
//   single-bit-per-stage square root (31 stages) and one CORDIC micro-rotation per stage, all fully pipelined.
// A two-entry output queue decouples the pipeline from the result channel.
// Reset (synchronous, active low) clears valid bits and the output queue.
// ----------------------------------------------------------------------------
// enu_pose_to_ned_euler_core
// ENU pose to NED position, velocity and Euler angles via pipelined CORDIC.
// ----------------------------------------------------------------------------
`include "enu_pose_to_ned_euler_core_defines.svh"

module enu_pose_to_ned_euler_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_east, pos_north, pos_up, quat_x, quat_y, quat_z, quat_w, vel_x, vel_y, vel_z
  input  logic [207:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // ned_north, ned_east, ned_down, roll_out, pitch_out, heading_out,
  // vel_north, vel_east, vel_down, zero pad
  output logic [191:0] out_tdata,
  // asin_clamped
  output logic         out_tuser
);

  localparam int NSTG = (CORDIC_STEPS > epn_pkg::MAX_ITER) ? epn_pkg::MAX_ITER : CORDIC_STEPS;
  localparam int NSQ  = epn_pkg::SQ_STEPS;

  logic en;
  logic push;
  logic pop;

  // input fields
  logic signed [15:0] qx, qy, qz, qw;
  assign qx = in_tdata[111:96];
  assign qy = in_tdata[127:112];
  assign qz = in_tdata[143:128];
  assign qw = in_tdata[159:144];

  // ---------------- stage A: products ----------------
  logic            va_r;
  epn_pkg::prod_t  prod_r;
  epn_pkg::side_t  side_a_r;
  epn_pkg::side_t  side_a_nxt;

  always_comb begin
    side_a_nxt.north   = in_tdata[63:32];
    side_a_nxt.east    = in_tdata[31:0];
    side_a_nxt.down    = epn_pkg::neg_sat32(in_tdata[95:64]);
    side_a_nxt.vn      = in_tdata[175:160];
    side_a_nxt.ve      = epn_pkg::neg_sat16(in_tdata[191:176]);
    side_a_nxt.vd      = epn_pkg::neg_sat16(in_tdata[207:192]);
    side_a_nxt.clamped = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r.xw <= qx * qw;
      prod_r.zy <= qz * qy;
      prod_r.xx <= qx * qx;
      prod_r.yy <= qy * qy;
      prod_r.wy <= qw * qy;
      prod_r.xz <= qx * qz;
      prod_r.zw <= qz * qw;
      prod_r.xy <= qx * qy;
      prod_r.zz <= qz * qz;
      side_a_r  <= side_a_nxt;
    end
  end

  // ---------------- stage B: sums, asin clamp ----------------
  logic           vb_r;
  epn_pkg::op_t   op_b_r;
  epn_pkg::op_t   op_b_nxt;
  epn_pkg::side_t side_b_r;
  epn_pkg::side_t side_b_nxt;
  logic           clamp_nxt;
  logic signed [epn_pkg::OW-1:0] s_raw;

  always_comb begin
    op_b_nxt.px  = (epn_pkg::OW'(prod_r.xw) + epn_pkg::OW'(prod_r.zy)) <<< 1;
    op_b_nxt.pxx = epn_pkg::ONE_Q30 -
                   ((epn_pkg::OW'(prod_r.xx) + epn_pkg::OW'(prod_r.yy)) <<< 1);
    op_b_nxt.hy  = (epn_pkg::OW'(prod_r.zw) + epn_pkg::OW'(prod_r.xy)) <<< 1;
    op_b_nxt.hx  = epn_pkg::ONE_Q30 -
                   ((epn_pkg::OW'(prod_r.yy) + epn_pkg::OW'(prod_r.zz)) <<< 1);
    s_raw        = (epn_pkg::OW'(prod_r.wy) - epn_pkg::OW'(prod_r.xz)) <<< 1;
    clamp_nxt    = 1'b0;
    if (s_raw > epn_pkg::ONE_Q30) begin
      op_b_nxt.s = 32'(epn_pkg::ONE_Q30);
      clamp_nxt  = 1'b1;
    end else if (s_raw < -epn_pkg::ONE_Q30) begin
      op_b_nxt.s = 32'(-epn_pkg::ONE_Q30);
      clamp_nxt  = 1'b1;
    end else begin
      op_b_nxt.s = 32'(s_raw);
    end
    side_b_nxt         = side_a_r;
    side_b_nxt.clamped = clamp_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_b_r   <= op_b_nxt;
      side_b_r <= side_b_nxt;
    end
  end

  // ---------------- stage C: s squared ----------------
  logic              vc0_r;
  epn_pkg::op_t      op_c_r;
  epn_pkg::side_t    side_c0_r;
  logic [60:0]       s2_r;
  logic signed [63:0] s2_full;

  assign s2_full = op_b_r.s * op_b_r.s;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r      <= s2_full[60:0];
      op_c_r    <= op_b_r;
      side_c0_r <= side_b_r;
    end
  end

  // ---------------- stage D: radicand ----------------
  logic           vd_r;
  epn_pkg::op_t   op_d_r;
  epn_pkg::side_t side_d_r;
  epn_pkg::sq_t   sq_d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_d_r.rem <= (epn_pkg::SQW'(1) << 60) - epn_pkg::SQW'(s2_r);
      sq_d_r.res <= '0;
      op_d_r     <= op_c_r;
      side_d_r   <= side_c0_r;
    end
  end

  // ---------------- square root stages ----------------
  logic [NSQ-1:0] vq_r;
  epn_pkg::sq_t   sq_q   [0:NSQ-1];
  epn_pkg::op_t   op_q_r [0:NSQ-1];
  epn_pkg::side_t side_q_r [0:NSQ-1];

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    if (k == 0) begin : g_first
      epn_sqrt_stage #(.K(k)) u_stage (.clk(clk), .en(en), .d(sq_d_r), .q(sq_q[k]));
      always_ff @(posedge clk) begin
        if (en) begin
          op_q_r[k]   <= op_d_r;
          side_q_r[k] <= side_d_r;
        end
      end
    end else begin : g_rest
      epn_sqrt_stage #(.K(k)) u_stage (.clk(clk), .en(en), .d(sq_q[k-1]), .q(sq_q[k]));
      always_ff @(posedge clk) begin
        if (en) begin
          op_q_r[k]   <= op_q_r[k-1];
          side_q_r[k] <= side_q_r[k-1];
        end
      end
    end
  end

  // ---------------- stage P: quadrant pre-rotation ----------------
  function automatic epn_pkg::lane_t prerot(input logic signed [epn_pkg::XW-1:0] y,
                                            input logic signed [epn_pkg::XW-1:0] x);
    epn_pkg::lane_t l;
    l.zero = (x == '0) && (y == '0);
    if (x[epn_pkg::XW-1]) begin
      if (!y[epn_pkg::XW-1]) begin
        l.x = y;
        l.y = -x;
        l.z = epn_pkg::HALF_PI_Q30;
      end else begin
        l.x = -y;
        l.y = x;
        l.z = -epn_pkg::HALF_PI_Q30;
      end
    end else begin
      l.x = x;
      l.y = y;
      l.z = '0;
    end
    return l;
  endfunction

  logic            vp_r;
  epn_pkg::lane3_t lane_p_r;
  epn_pkg::side_t  side_p_r;
  epn_pkg::op_t    op_last;
  logic [30:0]     root;

  assign op_last = op_q_r[NSQ-1];
  assign root    = sq_q[NSQ-1].res[30:0];

  always_ff @(posedge clk) begin
    if (en) begin
      lane_p_r.pitch <= prerot(epn_pkg::XW'(op_last.px), epn_pkg::XW'(op_last.pxx));
      lane_p_r.roll  <= prerot(epn_pkg::XW'(op_last.s), epn_pkg::XW'({1'b0, root}));
      lane_p_r.head  <= prerot(epn_pkg::XW'(op_last.hy), epn_pkg::XW'(op_last.hx));
      side_p_r       <= side_q_r[NSQ-1];
    end
  end

  // ---------------- CORDIC stages ----------------
  logic [NSTG-1:0] vk_r;
  epn_pkg::lane3_t lane_k   [0:NSTG-1];
  epn_pkg::side_t  side_k_r [0:NSTG-1];

  for (genvar i = 0; i < NSTG; i++) begin : g_cordic
    if (i == 0) begin : g_first
      epn_cordic_stage #(.I(i)) u_stage (.clk(clk), .en(en), .d(lane_p_r), .q(lane_k[i]));
      always_ff @(posedge clk) begin
        if (en) begin
          side_k_r[i] <= side_p_r;
        end
      end
    end else begin : g_rest
      epn_cordic_stage #(.I(i)) u_stage (.clk(clk), .en(en), .d(lane_k[i-1]),
                                         .q(lane_k[i]));
      always_ff @(posedge clk) begin
        if (en) begin
          side_k_r[i] <= side_k_r[i-1];
        end
      end
    end
  end

  // ---------------- final: angle conversion ----------------
  function automatic logic signed [16:0] to_q13(input epn_pkg::lane_t l);
    logic signed [epn_pkg::ZW-1:0] t;
    logic signed [epn_pkg::ZW-1:0] a;
    t = l.z + epn_pkg::ZW'(65536);
    a = t >>> 17;
    if (l.zero) return '0;
    if (a > epn_pkg::ZW'(epn_pkg::PI_Q13)) return epn_pkg::PI_Q13;
    if (a < -epn_pkg::ZW'(epn_pkg::PI_Q13)) return -epn_pkg::PI_Q13;
    return 17'(a);
  endfunction

  epn_pkg::lane3_t   lane_f;
  epn_pkg::side_t    side_f;
  epn_pkg::res_t     fres;
  logic signed [16:0] pitch_a, roll_a, psi_a;
  logic signed [16:0] roll_c;
  logic signed [17:0] head_a;

  assign lane_f = lane_k[NSTG-1];
  assign side_f = side_k_r[NSTG-1];

  always_comb begin
    pitch_a = to_q13(lane_f.pitch);
    roll_a  = to_q13(lane_f.roll);
    psi_a   = to_q13(lane_f.head);
    if (roll_a > epn_pkg::HALF_PI_Q13) begin
      roll_c = epn_pkg::HALF_PI_Q13;
    end else if (roll_a < -epn_pkg::HALF_PI_Q13) begin
      roll_c = -epn_pkg::HALF_PI_Q13;
    end else begin
      roll_c = roll_a;
    end
    head_a = 18'(epn_pkg::HALF_PI_Q13) - 18'(psi_a);
    if (head_a < -18'(epn_pkg::PI_Q13)) begin
      head_a = head_a + epn_pkg::TWO_PI_Q13;
    end
    if (head_a > 18'(epn_pkg::PI_Q13)) begin
      head_a = head_a - epn_pkg::TWO_PI_Q13;
    end
    fres.ned_north = side_f.north;
    fres.ned_east  = side_f.east;
    fres.ned_down  = side_f.down;
    fres.roll      = 15'(roll_c);
    fres.pitch     = 16'(pitch_a);
    fres.heading   = 16'(head_a);
    fres.vel_north = side_f.vn;
    fres.vel_east  = side_f.ve;
    fres.vel_down  = side_f.vd;
    fres.clamped   = side_f.clamped;
  end

  // ---------------- output queue ----------------
  epn_pkg::res_t fifo_r [0:1];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  epn_pkg::res_t head_item;

  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;
  assign push      = en && vk_r[NSTG-1];
  assign pop       = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
      vc0_r <= 1'b0;
      vd_r  <= 1'b0;
      vq_r  <= '0;
      vp_r  <= 1'b0;
      vk_r  <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (en) begin
        va_r  <= in_tvalid;
        vb_r  <= va_r;
        vc0_r <= vb_r;
        vd_r  <= vc0_r;
        vq_r  <= {vq_r[NSQ-2:0], vd_r};
        vp_r  <= vq_r[NSQ-1];
        vk_r  <= {vk_r[NSTG-2:0], vp_r};
      end
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= fres;
    end
  end

  assign head_item  = fifo_r[rp_r];
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {1'b0,
                       head_item.vel_down, head_item.vel_east, head_item.vel_north,
                       head_item.heading, head_item.pitch, head_item.roll,
                       head_item.ned_down, head_item.ned_east, head_item.ned_north};
  assign out_tuser  = head_item.clamped;

  // ---------------- assertions ----------------
  `EPN_ASSERT_IMP(a_no_overflow, push, cnt_r != 2'd2, "output queue overflow")
  `EPN_ASSERT_NXT(a_pop_drains, pop && !push, cnt_r == $past(cnt_r) - 2'd1, "queue count slip")
  `EPN_ASSERT_IMP(a_roll_range, push, (roll_c <= epn_pkg::HALF_PI_Q13) && (roll_c >= -epn_pkg::HALF_PI_Q13), "roll out of range")
  `EPN_ASSERT_IMP(a_head_range, push, (head_a <= 18'(epn_pkg::PI_Q13)) && (head_a >= -18'(epn_pkg::PI_Q13)), "heading out of range")

endmodule

[design/epn_sqrt_stage.sv]
// ----------------------------------------------------------------------------
// epn_sqrt_stage
// One restoring square root step: decides one root bit per stage.
// ----------------------------------------------------------------------------
module epn_sqrt_stage #(
  parameter int K = 0
) (
  input  logic         clk,
  input  logic         en,
  input  epn_pkg::sq_t d,
  output epn_pkg::sq_t q
);

  localparam logic [epn_pkg::SQW-1:0] BIT_VAL =
    epn_pkg::SQW'(1) << (60 - 2 * K);

  epn_pkg::sq_t q_r;
  epn_pkg::sq_t q_nxt;
  logic [epn_pkg::SQW-1:0] trial;

  always_comb begin
    trial = d.res + BIT_VAL;
    if (d.rem >= trial) begin
      q_nxt.rem = d.rem - trial;
      q_nxt.res = (d.res >> 1) + BIT_VAL;
    end else begin
      q_nxt.rem = d.rem;
      q_nxt.res = d.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

[design/epn_cordic_stage.sv]
// ----------------------------------------------------------------------------
// epn_cordic_stage
// One vectoring CORDIC micro-rotation, applied to all three angle lanes.
// ----------------------------------------------------------------------------
module epn_cordic_stage #(
  parameter int I = 0
) (
  input  logic            clk,
  input  logic            en,
  input  epn_pkg::lane3_t d,
  output epn_pkg::lane3_t q
);

  localparam logic signed [epn_pkg::ZW-1:0] ATAN_I =
    epn_pkg::ZW'(epn_pkg::ATAN_TAB[I]);

  function automatic epn_pkg::lane_t iter(input epn_pkg::lane_t l);
    epn_pkg::lane_t o;
    logic signed [epn_pkg::XW-1:0] x;
    logic signed [epn_pkg::XW-1:0] y;
    logic signed [epn_pkg::XW-1:0] xs;
    logic signed [epn_pkg::XW-1:0] ys;
    x  = l.x;
    y  = l.y;
    xs = x >>> I;
    ys = y >>> I;
    o.zero = l.zero;
    if (!y[epn_pkg::XW-1] && (y != '0)) begin
      o.x = x + ys;
      o.y = y - xs;
      o.z = l.z + ATAN_I;
    end else begin
      o.x = x - ys;
      o.y = y + xs;
      o.z = l.z - ATAN_I;
    end
    return o;
  endfunction

  epn_pkg::lane3_t q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q_r.pitch <= iter(d.pitch);
      q_r.roll  <= iter(d.roll);
      q_r.head  <= iter(d.head);
    end
  end

  assign q = q_r;

endmodule
